/* rtl/bcms_pkg.sv */
// Shared types, constants and helper functions for the battery charge mode sequencer.
`timescale 1ns / 1ps
`default_nettype none
package bcms_pkg;

    // Sample and accumulator sizes
    localparam int SAMPLE_BITS          = 10;
    localparam int SECONDS_PER_DECISION = 16;
    localparam int SEC_W                = $clog2(SECONDS_PER_DECISION);
    localparam int SUM_W                = SAMPLE_BITS + 4;
    localparam int AVG_SHIFT            = 4;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Field widths
    localparam int DIV_W      = 8;
    localparam int PERIOD_W   = 8;
    localparam int LIMIT_W    = 10;
    localparam int MODE_W     = 2;
    localparam int AVG_W      = 10;
    localparam int LED_W      = 3;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Reset values
    localparam logic [DIV_W-1:0]       TICK_DIVIDE_RST  = DIV_W'(64);
    localparam logic [PERIOD_W-1:0]    CHARGE_PER_RST   = PERIOD_W'(5);
    localparam logic [PERIOD_W-1:0]    DISCHARGE_PER_RST = PERIOD_W'(3);
    localparam logic [PERIOD_W-1:0]    GRID_PER_RST     = PERIOD_W'(2);
    localparam logic [LIMIT_W-1:0]     HIGH_LIMIT_RST   = LIMIT_W'(565);
    localparam logic [LIMIT_W-1:0]     GRID_LIMIT_RST   = LIMIT_W'(456);
    localparam logic [SAMPLE_BITS-1:0] AVG_RST          = SAMPLE_BITS'(512);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_DIVIDE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_PERIODS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_PERIODS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_PERIODS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ON_LIMIT     = 3'd5;

    // Mode codes as seen on the result stream
    localparam logic [MODE_W-1:0] CODE_CHARGE    = 2'd0;
    localparam logic [MODE_W-1:0] CODE_DISCHARGE = 2'd1;
    localparam logic [MODE_W-1:0] CODE_MEASURE   = 2'd2;
    localparam logic [MODE_W-1:0] CODE_GRID      = 2'd3;

    // LED bit positions
    localparam int LED_CHARGE    = 0;
    localparam int LED_DISCHARGE = 1;
    localparam int LED_MEASURE   = 2;

    typedef enum logic [3:0] {
        MODE_CHARGE    = 4'b0001,
        MODE_DISCHARGE = 4'b0010,
        MODE_MEASURE   = 4'b0100,
        MODE_GRID      = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [DIV_W-1:0]    tick_divide;
        logic [PERIOD_W-1:0] charge_periods;
        logic [PERIOD_W-1:0] discharge_periods;
        logic [PERIOD_W-1:0] grid_periods;
        logic [LIMIT_W-1:0]  high_limit;
        logic [LIMIT_W-1:0]  grid_on_limit;
    } cfg_t;

    typedef struct packed {
        logic [AVG_W-1:0]  average_voltage;
        logic              measure_led;
        logic              discharge_led;
        logic              charge_led;
        logic              fan_on;
        logic              grid_relay;
        logic              charge_relay;
        logic [MODE_W-1:0] mode;
    } res_t;

    // LED belonging to a mode; grid shares the charge LED
    function automatic logic [LED_W-1:0] mode_led(input mode_t m);
        logic [LED_W-1:0] led;
        led = '0;
        unique case (m)
            MODE_DISCHARGE: led[LED_DISCHARGE] = 1'b1;
            MODE_MEASURE:   led[LED_MEASURE]   = 1'b1;
            default:        led[LED_CHARGE]    = 1'b1;
        endcase
        return led;
    endfunction

    function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
        logic [MODE_W-1:0] code;
        unique case (m)
            MODE_DISCHARGE: code = CODE_DISCHARGE;
            MODE_MEASURE:   code = CODE_MEASURE;
            MODE_GRID:      code = CODE_GRID;
            default:        code = CODE_CHARGE;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

/* rtl/bcms_cfg.sv */
// Configuration register file of the battery charge mode sequencer.
`timescale 1ns / 1ps
`default_nettype none
module bcms_cfg (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              wr_en,
    input  wire  [bcms_pkg::CFG_IDX_W-1:0]   wr_index,
    input  wire  [bcms_pkg::CFG_DATA_W-1:0]  wr_data,
    output bcms_pkg::cfg_t                   cfg
);
    import bcms_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_TICK_DIVIDE:       cfg_next.tick_divide       = wr_data[DIV_W-1:0];
                CFG_CHARGE_PERIODS:    cfg_next.charge_periods    = wr_data[PERIOD_W-1:0];
                CFG_DISCHARGE_PERIODS: cfg_next.discharge_periods = wr_data[PERIOD_W-1:0];
                CFG_GRID_PERIODS:      cfg_next.grid_periods      = wr_data[PERIOD_W-1:0];
                CFG_HIGH_LIMIT:        cfg_next.high_limit        = wr_data[LIMIT_W-1:0];
                CFG_GRID_ON_LIMIT:     cfg_next.grid_on_limit     = wr_data[LIMIT_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_divide       <= TICK_DIVIDE_RST;
            cfg_reg.charge_periods    <= CHARGE_PER_RST;
            cfg_reg.discharge_periods <= DISCHARGE_PER_RST;
            cfg_reg.grid_periods      <= GRID_PER_RST;
            cfg_reg.high_limit        <= HIGH_LIMIT_RST;
            cfg_reg.grid_on_limit     <= GRID_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

/* rtl/bcms_core.sv */
// Mode sequencing state and the per-tick update of the battery charge mode sequencer.
`timescale 1ns / 1ps
`default_nettype none
module bcms_core (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               step,
    input  wire  [bcms_pkg::SAMPLE_BITS-1:0]  sample,
    input  bcms_pkg::cfg_t                    cfg,
    output bcms_pkg::res_t                    res
);
    import bcms_pkg::*;

    logic [DIV_W-1:0]       ovf_reg,   ovf_next;
    logic [SEC_W-1:0]       sec_reg,   sec_next;
    logic [PERIOD_W-1:0]    per_reg,   per_next;
    mode_t                  mode_reg,  mode_next;
    logic [SUM_W-1:0]       sum_reg,   sum_next;
    logic [SAMPLE_BITS-1:0] avg_reg,   avg_next;
    logic                   flash_reg, flash_next;
    logic [LED_W-1:0]       led_reg,   led_next;

    logic [DIV_W-1:0]       ovf_inc;
    logic                   sec_tick;
    logic [SUM_W:0]         sum_add;
    logic [SUM_W-1:0]       sum_sec;
    logic [SEC_W:0]         sec_inc;
    logic                   decide;
    logic [SAMPLE_BITS-1:0] avg_new;
    logic [PERIOD_W-1:0]    per_inc;
    logic [PERIOD_W-1:0]    per_limit;
    mode_t                  mode_pick;
    mode_t                  mode_dec;
    logic [LED_W-1:0]       led_dec;
    logic [SUM_W-1:0]       sum_dec;
    logic [PERIOD_W-1:0]    per_dec;
    logic [SAMPLE_BITS-1:0] avg_dec;
    logic [LED_W-1:0]       led_bit;

    // Overflow divider and second counter
    assign ovf_inc  = ovf_reg + DIV_W'(1);
    assign sec_tick = (ovf_inc == cfg.tick_divide);
    assign sec_inc  = {1'b0, sec_reg} + (SEC_W+1)'(1);
    assign decide   = (sec_inc >= (SEC_W+1)'(SECONDS_PER_DECISION));

    // Saturating sample accumulation while measuring
    assign sum_add = {1'b0, sum_reg} + (SUM_W+1)'(sample);
    assign sum_sec = (mode_reg == MODE_MEASURE)
                   ? (sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0])
                   : sum_reg;
    assign avg_new = sum_sec[SUM_W-1:AVG_SHIFT];

    // Period length of the current mode
    assign per_inc = per_reg + PERIOD_W'(1);
    always_comb
    begin
        unique case (mode_reg)
            MODE_DISCHARGE: per_limit = cfg.discharge_periods;
            MODE_GRID:      per_limit = cfg.grid_periods;
            default:        per_limit = cfg.charge_periods;
        endcase
    end

    // Mode chosen from the measured average
    always_comb
    begin
        priority if (avg_new < cfg.grid_on_limit)
            mode_pick = MODE_GRID;
        else if (avg_new > cfg.high_limit)
            mode_pick = MODE_DISCHARGE;
        else
            mode_pick = MODE_CHARGE;
    end

    // Decision at the end of a period
    always_comb
    begin
        mode_dec = mode_reg;
        led_dec  = led_reg;
        sum_dec  = sum_sec;
        per_dec  = per_reg;
        avg_dec  = avg_reg;
        if (decide)
        begin
            if (mode_reg == MODE_MEASURE)
            begin
                mode_dec = mode_pick;
                led_dec  = mode_led(mode_pick);
                sum_dec  = SUM_W'(avg_new);
                avg_dec  = avg_new;
                per_dec  = '0;
            end
            else
            begin
                per_dec = per_inc;
                if (per_inc == per_limit)
                begin
                    mode_dec = MODE_MEASURE;
                    led_dec  = mode_led(MODE_MEASURE);
                    sum_dec  = '0;
                end
            end
        end
    end

    // Next state, with the mode LED flashing once a second; in grid mode it stays lit
    assign led_bit = mode_led(mode_dec);
    always_comb
    begin
        ovf_next   = ovf_reg;
        sec_next   = sec_reg;
        per_next   = per_reg;
        mode_next  = mode_reg;
        sum_next   = sum_reg;
        avg_next   = avg_reg;
        flash_next = flash_reg;
        led_next   = led_reg;
        if (step)
        begin
            ovf_next = ovf_inc;
            if (sec_tick)
            begin
                ovf_next  = '0;
                sec_next  = decide ? '0 : sec_inc[SEC_W-1:0];
                per_next  = per_dec;
                mode_next = mode_dec;
                sum_next  = sum_dec;
                avg_next  = avg_dec;
                priority if (mode_dec == MODE_GRID)
                begin
                    led_next = led_dec | led_bit;
                end
                else if (!flash_reg)
                begin
                    led_next   = led_dec | led_bit;
                    flash_next = 1'b1;
                end
                else
                begin
                    led_next   = led_dec & ~led_bit;
                    flash_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg   <= '0;
            sec_reg   <= '0;
            per_reg   <= '0;
            mode_reg  <= MODE_CHARGE;
            sum_reg   <= '0;
            avg_reg   <= AVG_RST;
            flash_reg <= 1'b0;
            led_reg   <= mode_led(MODE_CHARGE);
        end
        else
        begin
            ovf_reg   <= ovf_next;
            sec_reg   <= sec_next;
            per_reg   <= per_next;
            mode_reg  <= mode_next;
            sum_reg   <= sum_next;
            avg_reg   <= avg_next;
            flash_reg <= flash_next;
            led_reg   <= led_next;
        end
    end

    // Result reflects the state after this tick
    always_comb
    begin
        res.mode            = mode_code(mode_next);
        res.charge_relay    = (mode_next == MODE_DISCHARGE) || (mode_next == MODE_MEASURE);
        res.grid_relay      = (mode_next == MODE_GRID);
        res.fan_on          = (mode_next != MODE_CHARGE);
        res.charge_led      = led_next[LED_CHARGE];
        res.discharge_led   = led_next[LED_DISCHARGE];
        res.measure_led     = led_next[LED_MEASURE];
        res.average_voltage = AVG_W'(avg_next);
    end

endmodule
`default_nettype wire

/* rtl/battery_charge_mode_sequencer.sv */
// Top level of the battery charge mode sequencer: stream handshakes, config port, checks.
//
// Usage:
//  s_tvalid/s_tready/s_tdata carry one timer overflow per beat with its ADC
//  sample in s_tdata[9:0]. Each input beat yields exactly one result beat on
//  m_tvalid/m_tready/m_tdata holding the mode, relay, fan and LED drives and
//  the latest 16-sample average, as they stand after that overflow.
//  cfg_valid/cfg_ready/cfg_index/cfg_data write the six configuration
//  registers; cfg_ready is always high, writes to unknown indexes are ignored.
//  Write configuration only while no beat is in flight.
//  Timing: an accepted input beat is held in the input register, passes
//  the state update and is loaded into the result register that drives
//  m_tvalid and m_tdata. Throughput is one beat per cycle while m_tready
//  stays high.
//  Reset: all counters clear, the block starts in charge mode with the charge
//  LED lit, the average reads 512 and the registers take their defaults.
//  Stalls: while m_tready is low the result register holds its beat; the
//  input register still takes one more beat, after which s_tready drops until
//  the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module battery_charge_mode_sequencer (
    input  wire                               clk,
    input  wire                               rst_n,
    // Input stream: [9:0] adc_sample, [15:10] zero
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [bcms_pkg::S_TDATA_W-1:0]    s_tdata,
    // Result stream: [1:0] mode, [2] charge_relay, [3] grid_relay, [4] fan_on,
    // [5] charge_led, [6] discharge_led, [7] measure_led,
    // [17:8] average_voltage, [23:18] zero
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [bcms_pkg::M_TDATA_W-1:0]    m_tdata,
    // Configuration write channel
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [bcms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [bcms_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bcms_pkg::*;

    logic                   in_full_reg,   in_full_next;
    logic [SAMPLE_BITS-1:0] in_sample_reg, in_sample_next;
    logic                   out_valid_reg, out_valid_next;
    res_t                   out_res_reg,   out_res_next;

    logic in_beat;
    logic advance;
    cfg_t cfg;
    res_t res;

    // Configuration registers
    assign cfg_ready = 1'b1;

    bcms_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Handshake control
    assign advance  = in_full_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_full_reg || advance;
    assign in_beat  = s_tvalid && s_tready;

    // State update for the registered beat
    bcms_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .sample (in_sample_reg),
        .cfg    (cfg),
        .res    (res)
    );

    // Input and result register next values
    always_comb
    begin
        in_sample_next = in_beat ? s_tdata[SAMPLE_BITS-1:0] : in_sample_reg;
        in_full_next   = in_beat ? 1'b1 : (advance ? 1'b0 : in_full_reg);
        out_res_next   = advance ? res : out_res_reg;
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_sample_reg <= in_sample_next;
        out_res_reg   <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_res_reg);

    // A held input beat keeps its sample until it moves on
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && !advance) |=> (in_full_reg && $stable(in_sample_reg)))
        else $error("input beat lost or changed while held");

    // A new result only follows a beat leaving the input register
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(advance))
        else $error("result beat without an input beat");

    // At most one mode LED is lit on a valid result beat
    a_led_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0({out_res_reg.measure_led, out_res_reg.discharge_led,
                               out_res_reg.charge_led}))
        else $error("more than one mode LED lit");

    // Fan and grid relay drives agree with the reported mode
    a_drives: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((out_res_reg.fan_on == (out_res_reg.mode != CODE_CHARGE))
                      && (out_res_reg.grid_relay == (out_res_reg.mode == CODE_GRID))))
        else $error("relay or fan drive does not match mode");

endmodule
`default_nettype wire
